@@ rtl/assert_macros.svh @@
// Assertion helpers included by the histogram unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLKED(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLKED(lbl, !(cond), msg)

`endif

@@ rtl/och_pkg.sv @@
`default_nettype none
package och_pkg;

  // Particle store.
  localparam int MAX_PARTICLES = 256;
  localparam int PART_AW       = $clog2(MAX_PARTICLES);
  localparam int PART_CW       = PART_AW + 1;
  localparam int PART_W        = 120;

  // Histogram store.
  localparam int MAX_BINS  = 64;
  localparam int BIN_AW    = 6;
  localparam int BINS_W    = 7;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 48;
  localparam int BIN_REC_W = CNT_W + SUM_W;
  localparam int MEAN_W    = 31;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BOX_X    = 2'd0;
  localparam logic [1:0] CFG_BOX_YZ   = 2'd1;
  localparam logic [1:0] CFG_BIN_W    = 2'd2;
  localparam logic [1:0] CFG_BINS_USE = 2'd3;

  // Request to the iterative divider.
  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [CNT_W-1:0]   divisor;
  } och_div_req_t;

endpackage
`default_nettype wire

@@ rtl/orientation_correlation_histogram_unit.sv @@
// Orientational pair correlation histogram.
// Input stream: tuser carries the operation (load, end frame, end frame and
// report); tdata carries position and orientation of one particle. Loads
// stream one word a cycle while the block is idle.
// An end-of-frame word walks every unordered pair of the loaded frame. Each
// pair is fetched (the first particle only when it changes), its squared
// distance and dot product are built on the shared multiplier, and a scan
// steps over the bins in use by squared edge; a pair that falls inside a bin
// is counted with a bin memory read and write.
// tready is low during the walk and during a report.
// A report then emits one word per bin in use. A bin that holds pairs needs a
// bin memory read and a 48-step divide before its word appears; an empty
// bin needs only the read. tlast marks the final bin. The output word is
// held while tready is low, and the block waits with it. After the last word
// the histograms are cleared. Reset sets control and configuration registers
// to defaults, empties the frame and clears all histogram bins at once; the
// particle store keeps no reset. Configuration writes take effect at once;
// the user must make them only while idle; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module orientation_correlation_histogram_unit
  import och_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  // Configuration write port.
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_idx_i,
  input  wire  [23:0]  cfg_data_i,
  // Input stream.
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], dir_x[87:72], dir_y[103:88],
  // dir_z[119:104]
  input  wire  [119:0] s_axis_tdata,
  // operation[1:0]
  input  wire  [1:0]   s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // bin_index[5:0], pair_count[37:6], mean_order[68:38], zero[71:69]
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_W2   = 5'd1;
  localparam logic [4:0] S_W2L  = 5'd2;
  localparam logic [4:0] S_RDI  = 5'd3;
  localparam logic [4:0] S_LDI  = 5'd4;
  localparam logic [4:0] S_RDJ  = 5'd5;
  localparam logic [4:0] S_DIF  = 5'd6;
  localparam logic [4:0] S_M0   = 5'd7;
  localparam logic [4:0] S_M1   = 5'd8;
  localparam logic [4:0] S_M2   = 5'd9;
  localparam logic [4:0] S_M3   = 5'd10;
  localparam logic [4:0] S_M4   = 5'd11;
  localparam logic [4:0] S_M5   = 5'd12;
  localparam logic [4:0] S_M6   = 5'd13;
  localparam logic [4:0] S_M7   = 5'd14;
  localparam logic [4:0] S_M8   = 5'd15;
  localparam logic [4:0] S_SCAN = 5'd16;
  localparam logic [4:0] S_BRD  = 5'd17;
  localparam logic [4:0] S_BWR  = 5'd18;
  localparam logic [4:0] S_NXT  = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;
  localparam logic [4:0] S_RRD  = 5'd21;
  localparam logic [4:0] S_RLD  = 5'd22;
  localparam logic [4:0] S_DIV  = 5'd23;
  localparam logic [4:0] S_OUT  = 5'd24;

  localparam int SW = 56;

  localparam logic signed [SUM_W:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W:0] SUM_MIN = -SUM_MAX - 49'sd1;

  // Configuration registers.
  logic [23:0] box_x_q, box_yz_q;
  logic [20:0] bin_w_q;
  logic [6:0]  bins_use_q;

  logic [4:0]          state_q, state_d;
  logic [PART_CW-1:0]  part_cnt_q;
  logic [PART_CW-1:0]  i_q, j_q;
  logic [1:0]          op_q;
  logic [PART_W-1:0]   pi_q;
  logic [47:0]         dj_q;
  logic signed [25:0]  dx_q, dy_q, dz_q;
  logic [50:0]         r2_q;
  logic signed [32:0]  dot_q;
  logic signed [39:0]  p2_q;
  logic [41:0]         w2_q;
  logic [SW-1:0]       s_lo_q, s_hi_q, e_q;
  logic [BINS_W-1:0]   b_q;
  logic [MAX_BINS-1:0] bin_vld_q;
  logic [CNT_W-1:0]    rcnt_q;
  logic [SUM_W-1:0]    rsum_q;
  logic [MEAN_W-1:0]   mean_q;

  logic                 in_acc;
  logic [BINS_W-1:0]    nb;
  logic [PART_W-1:0]    prd;
  logic [BIN_REC_W-1:0] brd;
  logic                 bwe;
  logic [BIN_REC_W-1:0] bwd;
  logic signed [32:0]   mul_a, mul_b;
  logic signed [65:0]   mul_p;
  och_div_req_t         div_req;
  logic                 div_busy;
  logic [SUM_W-1:0]     div_quo;
  logic [CNT_W-1:0]     old_cnt;
  logic [SUM_W-1:0]     old_sum;
  logic signed [SUM_W:0] sum_add;
  logic [SUM_W-1:0]     new_sum;
  logic [CNT_W-1:0]     new_cnt;
  logic [64:0]          sq_w;
  logic [36:0]          sq;
  logic [38:0]          sq3;
  logic signed [39:0]   p2_w;
  logic [SUM_W-1:0]     sum_mag;
  logic [MEAN_W-1:0]    mean_div, mean_dir;
  logic                 last_bin;

  // Minimum image along one axis, applied at most once.
  function automatic logic signed [25:0] min_image(input logic [23:0] a,
                                                   input logic [23:0] b,
                                                   input logic [23:0] box);
    logic signed [25:0] d;
    logic [25:0]        mag;
    d   = $signed({2'b00, a}) - $signed({2'b00, b});
    mag = d[25] ? 26'(-d) : 26'(d);
    if ({mag[24:0], 1'b0} > {2'b00, box}) begin
      d = d[25] ? (d + $signed({2'b00, box})) : (d - $signed({2'b00, box}));
    end
    return d;
  endfunction

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign nb     = (bins_use_q > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bins_use_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q    <= 24'd1048576;
      box_yz_q   <= 24'd1048576;
      bin_w_q    <= 21'd1638;
      bins_use_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOX_X:    box_x_q    <= cfg_data_i;
        CFG_BOX_YZ:   box_yz_q   <= cfg_data_i;
        CFG_BIN_W:    bin_w_q    <= cfg_data_i[20:0];
        CFG_BINS_USE: bins_use_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Particle store, written by loads and read for each new first particle and each second particle.
  och_ram #(.WIDTH(PART_W), .DEPTH(MAX_PARTICLES)) u_part_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (s_axis_tuser == OP_LOAD) &&
              (part_cnt_q < PART_CW'(MAX_PARTICLES))),
    .waddr_i (part_cnt_q[PART_AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i ((state_q == S_RDI) ? i_q[PART_AW-1:0] : j_q[PART_AW-1:0]),
    .rdata_o (prd)
  );

  // Histogram store: count in the low word, order sum above it.
  och_ram #(.WIDTH(BIN_REC_W), .DEPTH(MAX_BINS)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bwe),
    .waddr_i (b_q[BIN_AW-1:0]),
    .wdata_i (bwd),
    .raddr_i (b_q[BIN_AW-1:0]),
    .rdata_o (brd)
  );

  och_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  och_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_W2: begin
        mul_a = {12'd0, bin_w_q};
        mul_b = {12'd0, bin_w_q};
      end
      S_M0: begin
        mul_a = 33'(dx_q);
        mul_b = 33'(dx_q);
      end
      S_M1: begin
        mul_a = 33'(dy_q);
        mul_b = 33'(dy_q);
      end
      S_M2: begin
        mul_a = 33'(dz_q);
        mul_b = 33'(dz_q);
      end
      S_M3: begin
        mul_a = 33'($signed(pi_q[87:72]));
        mul_b = 33'($signed(dj_q[15:0]));
      end
      S_M4: begin
        mul_a = 33'($signed(pi_q[103:88]));
        mul_b = 33'($signed(dj_q[31:16]));
      end
      S_M5: begin
        mul_a = 33'($signed(pi_q[119:104]));
        mul_b = 33'($signed(dj_q[47:32]));
      end
      S_M7: begin
        mul_a = dot_q;
        mul_b = dot_q;
      end
      default: ;
    endcase
  end

  // P2 from the squared dot product, rounded to Q.28.
  always_comb begin
    sq_w = {1'b0, mul_p[63:0]} + 65'(1 << 27);
    sq   = sq_w[64:28];
    sq3  = {2'b00, sq} + {1'b0, sq, 1'b0};
    p2_w = $signed({2'b00, sq3[38:1]}) - 40'sd134217728;
  end

  // Histogram update with saturation; a bin never written reads as zero.
  always_comb begin
    old_cnt = bin_vld_q[b_q[BIN_AW-1:0]] ? brd[CNT_W-1:0] : '0;
    old_sum = bin_vld_q[b_q[BIN_AW-1:0]] ? brd[BIN_REC_W-1:CNT_W] : '0;
    sum_add = $signed({old_sum[SUM_W-1], old_sum}) + (SUM_W+1)'(p2_q);
    if (sum_add > SUM_MAX) begin
      new_sum = SUM_MAX[SUM_W-1:0];
    end else if (sum_add < SUM_MIN) begin
      new_sum = SUM_MIN[SUM_W-1:0];
    end else begin
      new_sum = sum_add[SUM_W-1:0];
    end
    new_cnt = (old_cnt == '1) ? old_cnt : (old_cnt + CNT_W'(1));
    bwe     = (state_q == S_BWR);
    bwd     = {new_sum, new_cnt};
  end

  // Mean from the divider quotient, or the sum itself for an empty bin.
  always_comb begin
    if (rsum_q[SUM_W-1]) begin
      mean_div = (div_quo > SUM_W'(1 << 30)) ? MEAN_W'(1 << 30) : MEAN_W'(-div_quo);
    end else begin
      mean_div = (div_quo > SUM_W'((1 << 30) - 1)) ? MEAN_W'((1 << 30) - 1)
                                                   : MEAN_W'(div_quo);
    end
    if ($signed(rsum_q) > 48'sd1073741823) begin
      mean_dir = MEAN_W'((1 << 30) - 1);
    end else if ($signed(rsum_q) < -48'sd1073741824) begin
      mean_dir = MEAN_W'(1 << 30);
    end else begin
      mean_dir = rsum_q[MEAN_W-1:0];
    end
    sum_mag  = rsum_q[SUM_W-1] ? SUM_W'(-rsum_q) : rsum_q;
    last_bin = (b_q + BINS_W'(1)) == nb;
  end

  always_comb begin
    div_req.start    = (state_q == S_RLD) && (old_cnt != '0);
    div_req.dividend = bin_vld_q[b_q[BIN_AW-1:0]] ?
                       (brd[BIN_REC_W-1] ? SUM_W'(-brd[BIN_REC_W-1:CNT_W])
                                         : brd[BIN_REC_W-1:CNT_W]) : '0;
    div_req.divisor  = old_cnt;
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && ((s_axis_tuser == OP_FRAME) || (s_axis_tuser == OP_REPORT))) begin
          state_d = S_W2;
        end
      end
      S_W2:  state_d = S_W2L;
      S_W2L: state_d = (part_cnt_q < PART_CW'(2)) ? S_DONE : S_RDI;
      S_RDI: state_d = S_LDI;
      S_LDI: state_d = S_RDJ;
      S_RDJ: state_d = S_DIF;
      S_DIF: state_d = S_M0;
      S_M0:  state_d = S_M1;
      S_M1:  state_d = S_M2;
      S_M2:  state_d = S_M3;
      S_M3:  state_d = S_M4;
      S_M4:  state_d = S_M5;
      S_M5:  state_d = S_M6;
      S_M6:  state_d = S_M7;
      S_M7:  state_d = S_M8;
      S_M8:  state_d = S_SCAN;
      S_SCAN: begin
        if (b_q >= nb) begin
          state_d = S_NXT;
        end else if ({5'd0, r2_q} < s_hi_q) begin
          state_d = ({5'd0, r2_q} > s_lo_q) ? S_BRD : S_NXT;
        end
      end
      S_BRD: state_d = S_BWR;
      S_BWR: state_d = S_NXT;
      S_NXT: begin
        if ((j_q + PART_CW'(1)) < part_cnt_q) begin
          state_d = S_RDJ;
        end else if ((i_q + PART_CW'(2)) < part_cnt_q) begin
          state_d = S_RDI;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (op_q != OP_REPORT) begin
          state_d = S_IDLE;
        end else if (nb == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_RRD;
        end
      end
      S_RRD: state_d = S_RLD;
      S_RLD: state_d = (old_cnt != '0) ? S_DIV : S_OUT;
      S_DIV: state_d = div_busy ? S_DIV : S_OUT;
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = last_bin ? S_IDLE : S_RRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      part_cnt_q <= '0;
      bin_vld_q  <= '0;
      op_q       <= OP_LOAD;
      i_q        <= '0;
      j_q        <= '0;
      b_q        <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q <= s_axis_tuser;
            if ((s_axis_tuser == OP_LOAD) && (part_cnt_q < PART_CW'(MAX_PARTICLES))) begin
              part_cnt_q <= part_cnt_q + PART_CW'(1);
            end
          end
          i_q <= '0;
          j_q <= PART_CW'(1);
        end
        S_M8: b_q <= '0;
        S_SCAN: begin
          if ((b_q < nb) && ({5'd0, r2_q} >= s_hi_q)) begin
            b_q <= b_q + BINS_W'(1);
          end
        end
        S_BWR: bin_vld_q[b_q[BIN_AW-1:0]] <= 1'b1;
        S_NXT: begin
          if ((j_q + PART_CW'(1)) < part_cnt_q) begin
            j_q <= j_q + PART_CW'(1);
          end else begin
            i_q <= i_q + PART_CW'(1);
            j_q <= i_q + PART_CW'(2);
          end
        end
        S_DONE: begin
          part_cnt_q <= '0;
          b_q        <= '0;
          if ((op_q == OP_REPORT) && (nb == '0)) begin
            bin_vld_q <= '0;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            b_q <= b_q + BINS_W'(1);
            if (last_bin) begin
              bin_vld_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_W2L: w2_q <= mul_p[41:0];
      S_LDI: pi_q <= prd;
      S_DIF: begin
        dx_q <= min_image(pi_q[23:0], prd[23:0], box_x_q);
        dy_q <= min_image(pi_q[47:24], prd[47:24], box_yz_q);
        dz_q <= min_image(pi_q[71:48], prd[71:48], box_yz_q);
        dj_q <= prd[119:72];
      end
      S_M1: r2_q  <= mul_p[50:0];
      S_M2: r2_q  <= r2_q + mul_p[50:0];
      S_M3: r2_q  <= r2_q + mul_p[50:0];
      S_M4: dot_q <= mul_p[32:0];
      S_M5: dot_q <= dot_q + mul_p[32:0];
      S_M6: dot_q <= dot_q + mul_p[32:0];
      S_M8: begin
        p2_q   <= p2_w;
        s_lo_q <= SW'(w2_q);
        s_hi_q <= SW'({w2_q, 2'b00});
        e_q    <= SW'({w2_q, 2'b00}) + SW'(w2_q);
      end
      S_SCAN: begin
        s_lo_q <= s_hi_q;
        s_hi_q <= s_hi_q + e_q;
        e_q    <= e_q + SW'({w2_q, 1'b0});
      end
      S_RLD: begin
        rcnt_q <= old_cnt;
        rsum_q <= old_sum;
      end
      default: ;
    endcase
    if ((state_q == S_RLD) && (old_cnt == '0)) begin
      mean_q <= bin_vld_q[b_q[BIN_AW-1:0]] ? MEAN_W'(0) : MEAN_W'(0);
    end
    if ((state_q == S_DIV) && !div_busy) begin
      mean_q <= (sum_mag == '0) ? MEAN_W'(0) : mean_div;
    end
  end

  // Output word.
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tlast  = last_bin;
  assign m_axis_tdata  = {3'b000, ((rcnt_q == '0) ? mean_dir : mean_q), rcnt_q,
                          b_q[BIN_AW-1:0]};

  `ASSERT_CLKED(a_cnt_bound, part_cnt_q <= PART_CW'(MAX_PARTICLES), "particle count overflow")
  `ASSERT_NEVER(a_rdy_out, s_axis_tready && m_axis_tvalid, "input taken during a report")
  `ASSERT_CLKED(a_rep_clear, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (bin_vld_q == '0), "histogram not cleared after report")
  `ASSERT_CLKED(a_div_done, m_axis_tvalid |-> !div_busy, "result shown before divide ended")

endmodule
`default_nettype wire

@@ rtl/och_ram.sv @@
`default_nettype none
module och_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/och_mul.sv @@
`default_nettype none
module och_mul
  import och_pkg::*;
(
  input  wire                clk_i,
  input  wire signed [32:0]  a_i,
  input  wire signed [32:0]  b_i,
  output logic signed [65:0] p_o
);

  // Shared signed multiplier with the product registered.
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule
`default_nettype wire

@@ rtl/och_div.sv @@
`default_nettype none
module och_div
  import och_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  och_div_req_t       req_i,
  output logic               busy_o,
  output logic [SUM_W-1:0]   quo_o
);

  logic [CNT_W:0]   rem_q, rem_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] dvs_q;
  logic [5:0]       step_q;
  logic             busy_q;
  logic [CNT_W:0]   shifted;
  logic             take;

  // One quotient bit a cycle while busy, restoring.
  always_comb begin
    shifted = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
    take    = shifted >= {1'b0, dvs_q};
    rem_d   = take ? (shifted - {1'b0, dvs_q}) : shifted;
    quo_d   = {quo_q[SUM_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      step_q <= 6'(SUM_W);
    end else if (busy_q) begin
      step_q <= step_q - 6'd1;
      if (step_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire
